FILE: hdl/lifo_preemptive_task_scheduler_assert.svh
// Assertion macros shared by the scheduler RTL.
`ifndef LIFO_PREEMPTIVE_TASK_SCHEDULER_ASSERT_SVH
`define LIFO_PREEMPTIVE_TASK_SCHEDULER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk_i and disabled during reset.
`define LPTS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk_i and disabled during reset.
`define LPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LPTS_ASSERT_IMPL(lbl, ante, cons, msg)
`define LPTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: hdl/lpts_pkg.sv
// Package with the widths, constants and types of the LIFO task scheduler.
package lpts_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int ID_W        = 10;
  localparam int MIN_W       = 11;
  localparam int WORK_W      = 10;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  typedef logic [ID_W-1:0]   task_id_t;
  typedef logic [MIN_W-1:0]  minute_t;
  typedef logic [WORK_W-1:0] work_t;

  typedef enum logic {
    STATUS_DONE = 1'b0,
    STATUS_DROP = 1'b1
  } status_e;

  typedef struct packed {
    task_id_t id;
    status_e  status;
  } result_t;

  typedef struct packed {
    task_id_t id;
    work_t    rem;
  } stack_entry_t;

endpackage

FILE: hdl/lpts_ifs.sv
// Valid/ready channel interfaces for task arrivals and task results.
interface lpts_task_if;
  import lpts_pkg::*;
  logic     valid;
  logic     ready;
  task_id_t task_id;
  minute_t  start_minute;
  work_t    work_minutes;
  logic     final_task;

  modport source (output valid, task_id, start_minute, work_minutes, final_task,
                  input ready);
  modport sink (input valid, task_id, start_minute, work_minutes, final_task,
                output ready);
endinterface

interface lpts_done_if;
  import lpts_pkg::*;
  logic     valid;
  logic     ready;
  task_id_t done_id;
  logic     status;
  logic     end_of_run;

  modport source (output valid, done_id, status, end_of_run, input ready);
  modport sink (input valid, done_id, status, end_of_run, output ready);
endinterface

FILE: hdl/lifo_preemptive_task_scheduler.sv
// LIFO preemptive task scheduler: one arrival in, zero or more task results out.
//
// Each arrival transaction on task_i preempts the running task. The minutes
// since the running task started are spent on it first; if it completes it is
// reported, and the leftover minutes drain the suspended stack newest first,
// a partly run top entry keeping its remainder. A task that does not complete
// is pushed, or reported with status 1 if the stack already holds
// lpts_pkg::STACK_DEPTH entries. A final arrival reports itself and then every
// suspended task newest first, after which the scheduler is back in its reset
// state. Each result is one transaction on done_o, and end_of_run marks the
// last result that an arrival causes. The scheduler takes one arrival at a
// time, and task_i.ready is high only while it waits for one. Each drained
// stack entry takes a registered read of the stack memory, then one pass
// through the shared subtract-and-compare unit; a top entry that is only
// trimmed takes a further trim step. A final arrival handles each flushed
// entry with a registered read, then the report. A stall on done_o holds
// the sequencer. The last result sits in the output register, so the next
// arrival can be taken before it is consumed.
module lifo_preemptive_task_scheduler (
  input logic       clk_i,
  input logic       rst_ni,
  lpts_task_if.sink task_i,
  lpts_done_if.source done_o
);
  import lpts_pkg::*;

  localparam int DIFF_W = MIN_W + 1;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE    = 4'd0;   // waiting for an arrival
  localparam logic [3:0] ST_GAP     = 4'd1;   // gap since running task started
  localparam logic [3:0] ST_CMPW    = 4'd2;   // does the running task complete
  localparam logic [3:0] ST_PUSH    = 4'd3;   // push remainder or drop it
  localparam logic [3:0] ST_DRAIN   = 4'd4;   // read top of stack if gap left
  localparam logic [3:0] ST_DRCMP   = 4'd5;   // does the top entry complete
  localparam logic [3:0] ST_TRIM    = 4'd6;   // shorten the top entry
  localparam logic [3:0] ST_INSTALL = 4'd7;   // arrival becomes running task
  localparam logic [3:0] ST_FLUSH   = 4'd8;   // read top of stack on a flush
  localparam logic [3:0] ST_FLRD    = 4'd9;   // report the flushed entry
  localparam logic [3:0] ST_FINISH  = 4'd10;  // release the held last result

  logic [3:0]   state_q, state_d, state_nxt;

  // Accepted arrival.
  task_id_t     in_id_q;
  minute_t      in_start_q;
  work_t        in_work_q;
  logic         in_final_q;

  // Running task.
  logic         run_v_q;
  task_id_t     run_id_q;
  minute_t      run_start_q;
  work_t        run_work_q;

  // Suspended stack.
  stack_entry_t stk_mem [STACK_DEPTH];
  stack_entry_t rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_dec;
  logic [PTR_W-1:0] top_addr;
  logic [PTR_W-1:0] push_addr;
  logic         stk_full;

  // Minutes still to spend in the current arrival.
  minute_t      gap_q;

  // Shared subtract-and-compare unit.
  minute_t      alu_a, alu_b;
  logic [DIFF_W-1:0] alu_diff;
  logic         alu_borrow;

  // Result path: one held result so end_of_run can be set on the last one,
  // then the output register.
  logic         pend_v_q;
  result_t      pend_q;
  logic         out_v_q;
  result_t      out_q;
  logic         out_eor_q;
  logic         out_free;

  logic         emit_req;
  result_t      emit_res;
  logic         emit_ok;
  logic         fin_req;
  logic         stall;
  logic         go;
  logic         fin_load;
  logic         in_take;

  assign cnt_dec   = cnt_q - CNT_W'(1);
  assign top_addr  = cnt_dec[PTR_W-1:0];
  assign push_addr = cnt_q[PTR_W-1:0];
  assign stk_full  = (cnt_q == CNT_W'(STACK_DEPTH));

  assign out_free = !out_v_q || done_o.ready;
  assign emit_ok  = !pend_v_q || out_free;
  assign in_take  = (state_q == ST_IDLE) && task_i.valid;

  // Operand selection for the shared unit.
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    case (state_q)
      ST_GAP: begin
        alu_a = in_start_q;
        alu_b = run_start_q;
      end
      ST_CMPW: begin
        alu_a = gap_q;
        alu_b = MIN_W'(run_work_q);
      end
      ST_PUSH: begin
        alu_a = MIN_W'(run_work_q);
        alu_b = gap_q;
      end
      ST_DRCMP: begin
        alu_a = gap_q;
        alu_b = MIN_W'(rd_q.rem);
      end
      ST_TRIM: begin
        alu_a = MIN_W'(rd_q.rem);
        alu_b = gap_q;
      end
      default: begin
        alu_a = '0;
        alu_b = '0;
      end
    endcase
  end

  assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
  assign alu_borrow = alu_diff[MIN_W];

  // Sequencer: next state and the result that each step produces.
  always_comb begin
    state_nxt = state_q;
    emit_req  = 1'b0;
    emit_res  = '{id: run_id_q, status: STATUS_DONE};
    fin_req   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (task_i.valid) state_nxt = ST_GAP;
      end
      ST_GAP: begin
        state_nxt = run_v_q ? ST_CMPW : ST_INSTALL;
      end
      ST_CMPW: begin
        if (!alu_borrow) begin
          emit_req  = 1'b1;
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (stk_full) begin
          emit_req = 1'b1;
          emit_res = '{id: run_id_q, status: STATUS_DROP};
        end
        state_nxt = ST_INSTALL;
      end
      ST_DRAIN: begin
        state_nxt = ((gap_q != '0) && (cnt_q != '0)) ? ST_DRCMP : ST_INSTALL;
      end
      ST_DRCMP: begin
        if (!alu_borrow) begin
          emit_req  = 1'b1;
          emit_res  = '{id: rd_q.id, status: STATUS_DONE};
          state_nxt = ST_DRAIN;
        end else begin
          state_nxt = ST_TRIM;
        end
      end
      ST_TRIM: begin
        state_nxt = ST_INSTALL;
      end
      ST_INSTALL: begin
        if (in_final_q) begin
          emit_req  = 1'b1;
          emit_res  = '{id: in_id_q, status: STATUS_DONE};
          state_nxt = ST_FLUSH;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FLUSH: begin
        state_nxt = (cnt_q != '0) ? ST_FLRD : ST_FINISH;
      end
      ST_FLRD: begin
        emit_req  = 1'b1;
        emit_res  = '{id: rd_q.id, status: STATUS_DONE};
        state_nxt = ST_FLUSH;
      end
      ST_FINISH: begin
        fin_req   = pend_v_q;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // A step waits while its result cannot move into the result path.
  assign stall    = (emit_req && !emit_ok) || (fin_req && !out_free);
  assign go       = !stall;
  assign state_d  = stall ? state_q : state_nxt;
  assign fin_load = go && fin_req;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      run_v_q  <= 1'b0;
      cnt_q    <= '0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (go) begin
        case (state_q)
          ST_INSTALL: run_v_q <= 1'b1;
          ST_PUSH: begin
            if (!stk_full) cnt_q <= cnt_q + CNT_W'(1);
          end
          ST_DRCMP: begin
            if (!alu_borrow) cnt_q <= cnt_dec;
          end
          ST_FLRD: cnt_q <= cnt_dec;
          ST_FLUSH: begin
            // A flush ends with the scheduler back in its reset state.
            if (cnt_q == '0) run_v_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end

      if (go && emit_req) begin
        pend_v_q <= 1'b1;
      end else if (fin_load) begin
        pend_v_q <= 1'b0;
      end

      if ((go && emit_req && pend_v_q) || fin_load) begin
        out_v_q <= 1'b1;
      end else if (done_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // Payload, the stack memory and its registered read port.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_id_q    <= task_i.task_id;
      in_start_q <= task_i.start_minute;
      in_work_q  <= task_i.work_minutes;
      in_final_q <= task_i.final_task;
    end

    if (state_q == ST_DRAIN || state_q == ST_FLUSH) begin
      rd_q <= stk_mem[top_addr];
    end

    if (go) begin
      case (state_q)
        ST_GAP: begin
          // Time running backwards counts as no time at all.
          gap_q <= alu_borrow ? '0 : alu_diff[MIN_W-1:0];
        end
        ST_CMPW: begin
          if (!alu_borrow) gap_q <= alu_diff[MIN_W-1:0];
        end
        ST_PUSH: begin
          if (!stk_full) begin
            stk_mem[push_addr] <= '{id: run_id_q, rem: alu_diff[WORK_W-1:0]};
          end
        end
        ST_DRCMP: begin
          if (!alu_borrow) gap_q <= alu_diff[MIN_W-1:0];
        end
        ST_TRIM: begin
          stk_mem[top_addr] <= '{id: rd_q.id, rem: alu_diff[WORK_W-1:0]};
        end
        ST_INSTALL: begin
          run_id_q    <= in_id_q;
          run_start_q <= in_start_q;
          run_work_q  <= in_work_q;
        end
        default: begin
        end
      endcase
    end

    if (go && emit_req) begin
      pend_q <= emit_res;
      if (pend_v_q) begin
        out_q     <= pend_q;
        out_eor_q <= 1'b0;
      end
    end else if (fin_load) begin
      out_q     <= pend_q;
      out_eor_q <= 1'b1;
    end
  end

  assign task_i.ready      = (state_q == ST_IDLE);
  assign done_o.valid      = out_v_q;
  assign done_o.done_id    = out_q.id;
  assign done_o.status     = out_q.status;
  assign done_o.end_of_run = out_eor_q;

  `include "lifo_preemptive_task_scheduler_assert.svh"

  // The stack never holds more entries than it has room for.
  `LPTS_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_q <= CNT_W'(STACK_DEPTH), "stack count overflow")
  // A new arrival is only taken once no result of the last one is still held.
  `LPTS_ASSERT_IMPL(a_idle_no_pend, state_q == ST_IDLE, !pend_v_q, "held result while idle")
  // Releasing the last result of an arrival returns the sequencer to idle.
  `LPTS_ASSERT_NEXT(a_fin_idle, fin_load, state_q == ST_IDLE && out_eor_q, "bad finish")

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the LIFO preemptive task scheduler.
module tb;
  import lpts_pkg::*;

  // An arrival waiting to be driven. A set hold bit makes the driver wait
  // until every predicted result has been consumed before presenting it.
  typedef struct {
    task_id_t id;
    minute_t  start;
    work_t    work;
    logic     is_final;
    bit       hold;
  } arrival_t;

  // One predicted transaction on the result channel.
  typedef struct {
    task_id_t id;
    status_e  status;
    logic     run_end;
  } done_result_t;

  localparam int RANDOM_ARRIVALS = 150;
  localparam int QUIET_LIMIT     = 4000;
  localparam int TAIL_CYCLES     = 2 * STACK_DEPTH + 24;
  localparam int PHASE_LEN       = 16;

  logic clk_i = 1'b0;
  logic rst_ni;

  lpts_task_if task_if();
  lpts_done_if done_if();

  lifo_preemptive_task_scheduler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .task_i (task_if),
    .done_o (done_if)
  );

  always #2 clk_i = ~clk_i;

  arrival_t     pending_arrivals[$];
  done_result_t expected_done[$];
  int           arrivals_accepted = 0;
  int           mismatches = 0;
  int           quiet_cycles = 0;

  // Scheduler state as this testbench sees it: the running task and the
  // stack of suspended tasks with the minutes each one still needs.
  logic     run_valid;
  task_id_t run_id;
  minute_t  run_start;
  work_t    run_work;
  task_id_t susp_id[STACK_DEPTH];
  int       susp_rem[STACK_DEPTH];
  int       susp_count;

  function automatic done_result_t done_entry(task_id_t id, status_e status);
    done_result_t r;
    r.id      = id;
    r.status  = status;
    r.run_end = 1'b0;
    return r;
  endfunction

  task automatic clear_schedule();
    run_valid  = 1'b0;
    run_id     = '0;
    run_start  = '0;
    run_work   = '0;
    susp_count = 0;
  endtask

  // Applies one accepted arrival to the scheduler state and queues every
  // result it causes, marking the last one as the end of the run.
  task automatic schedule_arrival(task_id_t id, minute_t start, work_t work,
                                  logic is_final);
    done_result_t produced[$];
    int           gap;
    int           top;
    if (run_valid) begin
      // Time running backwards gives the running task no minutes at all.
      gap = (start >= run_start) ? int'(start) - int'(run_start) : 0;
      if (gap >= int'(run_work)) begin
        produced.insert(produced.size(), done_entry(run_id, STATUS_DONE));
        gap -= int'(run_work);
        // Leftover minutes go to the suspended tasks, newest first. A top
        // entry that does not finish keeps what it still needs.
        while (gap > 0 && susp_count > 0) begin
          top = susp_count - 1;
          if (susp_rem[top] <= gap) begin
            produced.insert(produced.size(), done_entry(susp_id[top], STATUS_DONE));
            gap -= susp_rem[top];
            susp_count--;
          end else begin
            susp_rem[top] -= gap;
            gap = 0;
          end
        end
      end else if (susp_count < STACK_DEPTH) begin
        susp_id[susp_count]  = run_id;
        susp_rem[susp_count] = int'(run_work) - gap;
        susp_count++;
      end else begin
        // No room on the stack: the preempted task is dropped.
        produced.insert(produced.size(), done_entry(run_id, STATUS_DROP));
      end
    end
    run_valid = 1'b1;
    run_id    = id;
    run_start = start;
    run_work  = work;
    if (is_final) begin
      // A final arrival reports itself, then flushes the whole stack.
      produced.insert(produced.size(), done_entry(id, STATUS_DONE));
      while (susp_count > 0) begin
        produced.insert(produced.size(),
                        done_entry(susp_id[susp_count-1], STATUS_DONE));
        susp_count--;
      end
      clear_schedule();
    end
    if (produced.size() != 0) produced[produced.size()-1].run_end = 1'b1;
    foreach (produced[i]) expected_done.insert(expected_done.size(), produced[i]);
  endtask

  task automatic queue_arrival(int id, int start, int work, bit is_final, bit hold);
    arrival_t a;
    a.id       = task_id_t'(id);
    a.start    = minute_t'(start);
    a.work     = work_t'(work);
    a.is_final = is_final;
    a.hold     = hold;
    pending_arrivals.insert(pending_arrivals.size(), a);
  endtask

  // The run walks through four idling phases as arrivals are accepted:
  // no idling, an idle sender, a stalling receiver, and both a little.
  function automatic int sender_gap_pct();
    case ((arrivals_accepted / PHASE_LEN) % 4)
      1: return 75;
      3: return 14;
      default: return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct();
    case ((arrivals_accepted / PHASE_LEN) % 4)
      2: return 75;
      3: return 14;
      default: return 0;
    endcase
  endfunction

  // Arrival driver. An accepted transaction is handed to the predictor from
  // the values still on the bus; a presented arrival stays put until taken.
  always @(posedge clk_i) begin : arrival_driver
    arrival_t nxt;
    bit       go;
    if (rst_ni) begin
      if (task_if.valid && task_if.ready) begin
        schedule_arrival(task_if.task_id, task_if.start_minute,
                         task_if.work_minutes, task_if.final_task);
        arrivals_accepted++;
      end
      if (!task_if.valid || task_if.ready) begin
        go = pending_arrivals.size() != 0 &&
             $urandom_range(99) >= sender_gap_pct();
        if (go && pending_arrivals[0].hold && expected_done.size() != 0) go = 0;
        if (go) begin
          nxt = pending_arrivals.pop_front();
          task_if.valid        <= 1'b1;
          task_if.task_id      <= nxt.id;
          task_if.start_minute <= nxt.start;
          task_if.work_minutes <= nxt.work;
          task_if.final_task   <= nxt.is_final;
        end else begin
          task_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Every accepted result transaction is checked field by
  // field against the oldest prediction; ready is redrawn every cycle.
  always @(posedge clk_i) begin : result_monitor
    done_result_t want;
    if (rst_ni) begin
      if (done_if.valid && done_if.ready) begin
        if (expected_done.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual id=%0d status=%0d end=%0d",
                   $time, done_if.done_id, done_if.status, done_if.end_of_run);
          mismatches++;
        end else begin
          want = expected_done.pop_front();
          if (done_if.done_id !== want.id) begin
            $display("%0t: done_id mismatch: expected %0d, actual %0d",
                     $time, want.id, done_if.done_id);
            mismatches++;
          end
          if (done_if.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, done_if.status);
            mismatches++;
          end
          if (done_if.end_of_run !== want.run_end) begin
            $display("%0t: end_of_run mismatch: expected %0d, actual %0d",
                     $time, want.run_end, done_if.end_of_run);
            mismatches++;
          end
        end
      end
      done_if.ready <= ($urandom_range(99) >= sink_stall_pct());
    end
  end

  // Cycles in a row in which neither channel moved a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (task_if.valid && task_if.ready) || (done_if.valid && done_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    int      kind;
    int      n;
    int      t;
    bit      first_batch;
    int      target;
    rst_ni               = 1'b0;
    task_if.valid        = 1'b0;
    task_if.task_id      = '0;
    task_if.start_minute = '0;
    task_if.work_minutes = '0;
    task_if.final_task   = 1'b0;
    done_if.ready        = 1'b0;
    clear_schedule();

    // Directed part. The first arrival after reset only starts running; a
    // zero-work task finishes on the next arrival even with no time passing.
    queue_arrival(0,    0,    0,    0, 0);
    queue_arrival(1023, 0,    1023, 0, 0);
    queue_arrival(5,    10,   5,    0, 0);
    // Time going backwards pushes the running task with all its work.
    queue_arrival(6,    5,    3,    0, 0);
    // A large gap finishes the running task and drains the whole stack.
    queue_arrival(7,    1439, 1,    0, 0);
    queue_arrival(8,    1439, 1,    1, 0);
    // A final arrival with nothing running, with zero work.
    queue_arrival(512,  0,    0,    1, 0);
    // A partly drained stack top keeps its remainder until the final arrival drains it.
    queue_arrival(100,  0,    10,   0, 0);
    queue_arrival(101,  2,    10,   0, 0);
    queue_arrival(102,  4,    5,    0, 0);
    queue_arrival(103,  20,   2,    0, 0);
    queue_arrival(104,  2047, 1023, 1, 0);
    // A gap exactly equal to the work, then a final push and flush.
    queue_arrival(200,  100,  30,   0, 0);
    queue_arrival(201,  130,  1,    0, 0);
    queue_arrival(202,  130,  7,    1, 0);
    queue_arrival(341,  1024, 682,  0, 0);
    queue_arrival(682,  1024, 341,  1, 0);

    // Random part, built from batches. The first is a deep batch that fills
    // the stack, can overflow it and can flush the most results one arrival can
    // cause; it also waits for the directed results to drain first.
    target      = pending_arrivals.size() + RANDOM_ARRIVALS;
    first_batch = 1;
    while (pending_arrivals.size() < target) begin
      kind = first_batch ? 0 : $urandom_range(9);
      if (kind == 0) begin
        n = STACK_DEPTH + 1 + $urandom_range(2);
        t = $urandom_range(1000);
        for (int i = 0; i < n; i++)
          queue_arrival($urandom_range(1023), t, $urandom_range(1, 1023), 0,
                        i == 0 && (first_batch || $urandom_range(3) == 0));
        queue_arrival($urandom_range(1023), t + $urandom_range(400),
                      $urandom_range(1023), 1, 0);
      end else if (kind <= 6) begin
        // A well-formed batch: rising start minutes, mostly short work.
        n = $urandom_range(2, 10);
        t = $urandom_range(1200);
        for (int i = 0; i < n; i++) begin
          t += $urandom_range(40);
          if (t > 1439) t = 1439;
          queue_arrival($urandom_range(1023), t,
                        ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                 : $urandom_range(1, 60),
                        i == n - 1 && $urandom_range(3) != 0,
                        i == 0 && $urandom_range(7) == 0);
        end
      end else begin
        // Noise: any field value, including out-of-order minutes.
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++)
          queue_arrival($urandom_range(1023), $urandom_range(2047),
                        $urandom_range(1023), $urandom_range(3) == 0, 0);
      end
      first_batch = 0;
    end
    // Close whatever batch is still open so the stack ends empty.
    queue_arrival($urandom_range(1023), 1439, $urandom_range(1023), 1, 1);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_arrivals.size() != 0 || task_if.valid) @(posedge clk_i);
    while (expected_done.size() != 0) @(posedge clk_i);
    // Give a stray extra result time to show up before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
